### rtl/core/sm4i_pkg.sv
`default_nettype none
package sm4i_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    localparam int NUM_ELEM      = 12;
    localparam int IN_W          = NUM_ELEM * ELEM_W;
    // row_index + four columns, padded to whole bytes
    localparam int OUT_W         = 136;
    localparam int SUM_W         = 64;
    localparam int QUEUE_DEPTH   = 2;

    // one classified matrix: element signs and magnitudes, sum of squares
    typedef struct packed {
        logic                                singular;
        logic [SUM_W-1:0]                    s;
        logic [NUM_ELEM-1:0]                 neg;
        logic [NUM_ELEM-1:0][ELEM_W-1:0]     mag;
    } sm4i_entry_t;

    localparam int ENTRY_W = $bits(sm4i_entry_t);

    typedef struct packed {
        logic full;
        logic empty;
    } sm4i_qstat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIV,
        ST_BMUL,
        ST_BSCL,
        ST_TMUL,
        ST_TACC,
        ST_TFIN,
        ST_OUT
    } sm4i_state_t;

    // sign and magnitude to a saturated 32-bit two's complement value
    function automatic logic [ELEM_W-1:0] pack32(input logic neg, input logic [SUM_W-1:0] mag);
        logic [ELEM_W-1:0] res;
        if (!neg)
        begin
            res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[ELEM_W-1:0];
        end
        else
        begin
            res = (mag >= 64'h8000_0000) ? 32'h8000_0000 : (~mag[ELEM_W-1:0] + 32'd1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/core/sm4i_fifo.sv
`default_nettype none
module sm4i_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   wdata,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        rdata,
    output sm4i_pkg::sm4i_qstat_t   stat
);
    import sm4i_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (AW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule
`default_nettype wire

### rtl/core/sm4i_front.sv
`default_nettype none
module sm4i_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [sm4i_pkg::IN_W-1:0]  in_data,
    input  wire sm4i_pkg::sm4i_qstat_t      qstat,
    output logic                            push,
    output sm4i_pkg::sm4i_entry_t           entry
);
    import sm4i_pkg::*;

    logic                               busy_reg;
    logic [1:0]                         step_reg;
    logic [SUM_W-1:0]                   acc_reg;
    logic [NUM_ELEM-1:0]                neg_reg;
    logic [NUM_ELEM-1:0][ELEM_W-1:0]    mag_reg;
    logic                               accept;
    logic                               done;
    logic [SUM_W-1:0]                   sq;
    logic [ELEM_W-1:0]                  sq_src;

    assign done     = busy_reg && (step_reg == 2'd3);
    assign push     = done && !qstat.full;
    assign in_ready = !busy_reg || push;
    assign accept   = in_valid && in_ready;

    // one square of the first row per cycle
    assign sq_src = mag_reg[{2'b00, step_reg}];
    assign sq     = sq_src * sq_src;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (push)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && !done)
            begin
                step_reg <= step_reg + 2'd1;
            end
        end
    end

    // split elements into sign and magnitude, accumulate squares
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg <= '0;
            for (int e = 0; e < NUM_ELEM; e++)
            begin
                neg_reg[e] <= in_data[e*ELEM_W + ELEM_W - 1];
                mag_reg[e] <= in_data[e*ELEM_W + ELEM_W - 1] ?
                              (~in_data[e*ELEM_W +: ELEM_W] + 32'd1) :
                              in_data[e*ELEM_W +: ELEM_W];
            end
        end
        else if (busy_reg && !done)
        begin
            acc_reg <= acc_reg + sq;
        end
    end

    assign entry.singular = (acc_reg == '0);
    assign entry.s        = acc_reg;
    assign entry.neg      = neg_reg;
    assign entry.mag      = mag_reg;

endmodule
`default_nettype wire

### rtl/core/sm4i_back.sv
`default_nettype none
module sm4i_back #(
    parameter int FRAC_BITS = sm4i_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sm4i_pkg::sm4i_qstat_t      qstat,
    input  wire sm4i_pkg::sm4i_entry_t      qdata,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      out_row,
    output logic [sm4i_pkg::ELEM_W-1:0]     out_col0,
    output logic [sm4i_pkg::ELEM_W-1:0]     out_col1,
    output logic [sm4i_pkg::ELEM_W-1:0]     out_col2,
    output logic [sm4i_pkg::ELEM_W-1:0]     out_col3,
    output logic                            out_singular,
    output logic                            out_last
);
    import sm4i_pkg::*;

    sm4i_state_t        state_reg;
    sm4i_state_t        state_next;
    logic [4:0]         cnt_reg;
    sm4i_entry_t        ent_reg;
    logic [SUM_W-1:0]   sn_reg;
    logic [5:0]         k_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [ELEM_W-1:0]  r_reg;
    logic [1:0]         i_reg;
    logic [1:0]         j_reg;
    logic [SUM_W-1:0]   prod_reg;
    logic               pneg_reg;
    logic [ELEM_W-1:0]  blk_reg [3];
    logic [ELEM_W-1:0]  bmag_reg [3];
    logic [2:0]         bneg_reg;
    logic [SUM_W-1:0]   pos_reg;
    logic [SUM_W-1:0]   negs_reg;
    logic [1:0]         row_reg;
    logic [ELEM_W-1:0]  col0_reg;
    logic [ELEM_W-1:0]  col1_reg;
    logic [ELEM_W-1:0]  col2_reg;
    logic [ELEM_W-1:0]  col3_reg;
    logic               sing_reg;
    logic               last_reg;

    logic               taken;
    logic [6:0]         nw;
    logic               top_zero;
    logic [SUM_W:0]     rem2;
    logic               qbit;
    logic signed [7:0]  sh;
    logic [6:0]         rsh;
    logic [SUM_W-1:0]   smag;
    logic               sneg;
    logic [ELEM_W-1:0]  sval;
    logic [ELEM_W-1:0]  sclamp;
    logic               rneg;
    logic [SUM_W-1:0]   tmag;
    logic [SUM_W:0]     tround;

    assign taken = (state_reg == ST_OUT) && out_ready;

    // normalize step: window of 32, 16, 8, 4, 2, 1 bits
    assign nw       = 7'd32 >> cnt_reg[2:0];
    assign top_zero = ((sn_reg >> (7'd64 - nw)) == '0);

    // restoring divide step of 2^94 by the normalized sum
    assign rem2 = {rem_reg, 1'b0};
    assign qbit = (rem2 >= {1'b0, sn_reg});

    // block element scaling by 2^(2F - k - 31)
    always_comb
    begin
        sh   = 8'(2 * FRAC_BITS - 31) - $signed({2'b00, k_reg});
        rsh  = 7'(-sh);
        smag = '0;
        if (!sh[7])
        begin
            if ((prod_reg >> (7'd32 - 7'(sh))) != '0)
            begin
                smag = 64'h1_0000_0000;
            end
            else
            begin
                smag = prod_reg << sh[4:0];
            end
        end
        else if (rsh < 7'd64)
        begin
            smag = ((prod_reg >> (rsh - 7'd1)) + 64'd1) >> 1;
        end
        sneg   = ent_reg.neg[{j_reg, i_reg}];
        sval   = pack32(sneg, smag);
        if (sneg)
        begin
            sclamp = (smag >= 64'h8000_0000) ? 32'h8000_0000 : smag[ELEM_W-1:0];
        end
        else
        begin
            sclamp = (smag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : smag[ELEM_W-1:0];
        end
    end

    // translation: negated dot product, rounded
    always_comb
    begin
        rneg   = pos_reg > negs_reg;
        tmag   = rneg ? (pos_reg - negs_reg) : (negs_reg - pos_reg);
        tround = ({1'b0, tmag} + ((SUM_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = qdata.singular ? ST_OUT : ST_NORM;
                end
            end
            ST_NORM: if (cnt_reg == 5'd5) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 5'd31) state_next = ST_BMUL;
            ST_BMUL: state_next = ST_BSCL;
            ST_BSCL: state_next = (j_reg == 2'd2) ? ST_TMUL : ST_BMUL;
            ST_TMUL: state_next = ST_TACC;
            ST_TACC: state_next = (j_reg == 2'd2) ? ST_TFIN : ST_TMUL;
            ST_TFIN: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (i_reg != 2'd2)
                    begin
                        state_next = ST_BMUL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop          = (state_reg == ST_IDLE) && !qstat.empty;
        out_valid    = (state_reg == ST_OUT);
        out_row      = row_reg;
        out_col0     = col0_reg;
        out_col1     = col1_reg;
        out_col2     = col2_reg;
        out_col3     = col3_reg;
        out_singular = sing_reg;
        out_last     = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ent_reg  <= qdata;
                sn_reg   <= qdata.s;
                k_reg    <= 6'd63;
                cnt_reg  <= '0;
                row_reg  <= '0;
                col0_reg <= '0;
                col1_reg <= '0;
                col2_reg <= '0;
                col3_reg <= '0;
                sing_reg <= 1'b1;
                last_reg <= 1'b1;
            end
            ST_NORM:
            begin
                if (top_zero)
                begin
                    sn_reg <= sn_reg << nw;
                    k_reg  <= k_reg - nw[5:0];
                end
                rem_reg <= 64'h4000_0000_0000_0000;
                cnt_reg <= (cnt_reg == 5'd5) ? '0 : cnt_reg + 5'd1;
            end
            ST_DIV:
            begin
                rem_reg  <= qbit ? 64'(rem2 - {1'b0, sn_reg}) : rem2[SUM_W-1:0];
                r_reg    <= {r_reg[ELEM_W-2:0], qbit};
                cnt_reg  <= cnt_reg + 5'd1;
                i_reg    <= '0;
                j_reg    <= '0;
                pos_reg  <= '0;
                negs_reg <= '0;
            end
            ST_BMUL:
            begin
                prod_reg <= ent_reg.mag[{j_reg, i_reg}] * r_reg;
            end
            ST_BSCL:
            begin
                blk_reg[j_reg]  <= sval;
                bmag_reg[j_reg] <= sclamp;
                bneg_reg[j_reg] <= sneg;
                j_reg           <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
            end
            ST_TMUL:
            begin
                prod_reg <= bmag_reg[j_reg] * ent_reg.mag[{j_reg, 2'd3}];
                pneg_reg <= bneg_reg[j_reg] != ent_reg.neg[{j_reg, 2'd3}];
            end
            ST_TACC:
            begin
                if (pneg_reg)
                begin
                    negs_reg <= negs_reg + prod_reg;
                end
                else
                begin
                    pos_reg <= pos_reg + prod_reg;
                end
                j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
            end
            ST_TFIN:
            begin
                row_reg  <= i_reg;
                col0_reg <= blk_reg[0];
                col1_reg <= blk_reg[1];
                col2_reg <= blk_reg[2];
                col3_reg <= pack32(rneg, tround[SUM_W-1:0]);
                sing_reg <= 1'b0;
                last_reg <= 1'b0;
            end
            ST_OUT:
            begin
                if (taken && !last_reg)
                begin
                    // last row of the inverse is fixed
                    if (i_reg == 2'd2)
                    begin
                        row_reg  <= 2'd3;
                        col0_reg <= '0;
                        col1_reg <= '0;
                        col2_reg <= '0;
                        col3_reg <= 32'(64'd1 << FRAC_BITS);
                        last_reg <= 1'b1;
                    end
                    i_reg    <= i_reg + 2'd1;
                    j_reg    <= '0;
                    pos_reg  <= '0;
                    negs_reg <= '0;
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/similarity_matrix4_inverse.sv
// channel     dir  tdata                                       tuser     tlast
// s_axis      in   m00..m03, m10..m13, m20..m23 (32b each)     -         -
// m_axis      out  row_index, col0, col1, col2, col3 (+6 pad)  singular  last row
//
// the front squares m00, m01 and m02 of the first row with one multiplier
// and queues the classified matrix (two entries deep); the back takes it
// from the queue, normalizes, runs a restoring divide (one quotient bit a
// cycle), computes rows 0 to 2 through one shared product register and
// gives the fixed row 3; a singular matrix goes straight to the output;
// the front can take a new matrix while the back still works on the last one
// reset is asynchronous and active low; a stalled m_axis holds the back only,
// the front keeps taking requests until the queue is full
`default_nettype none
module similarity_matrix4_inverse #(
    parameter int FRAC_BITS = sm4i_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // m00, m01, m02, m03, m10, ..., m23 from bit 0 up, 32 bits each
    input  wire logic [sm4i_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // row_index[1:0], col0, col1, col2, col3 from bit 0 up, zero pad on top
    output logic [sm4i_pkg::OUT_W-1:0]       m_axis_tdata,
    // singular
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast
);
    import sm4i_pkg::*;

    logic               push;
    logic               pop;
    sm4i_entry_t        wentry;
    sm4i_entry_t        rentry;
    logic [ENTRY_W-1:0] rbits;
    sm4i_qstat_t        qstat;
    logic [1:0]         row;
    logic [ELEM_W-1:0]  col0;
    logic [ELEM_W-1:0]  col1;
    logic [ELEM_W-1:0]  col2;
    logic [ELEM_W-1:0]  col3;

    sm4i_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .qstat    (qstat),
        .push     (push),
        .entry    (wentry)
    );

    sm4i_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wentry),
        .pop   (pop),
        .rdata (rbits),
        .stat  (qstat)
    );

    assign rentry = rbits;

    sm4i_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .qdata        (rentry),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_row      (row),
        .out_col0     (col0),
        .out_col1     (col1),
        .out_col2     (col2),
        .out_col3     (col3),
        .out_singular (m_axis_tuser),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, col3, col2, col1, col0, row};

endmodule
`default_nettype wire

### rtl/core/sm4i_checker.sv
`default_nettype none
module sm4i_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_axis_tvalid,
    input wire logic                        s_axis_tready,
    input wire logic [sm4i_pkg::IN_W-1:0]   s_axis_tdata,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [sm4i_pkg::OUT_W-1:0]  m_axis_tdata,
    input wire logic                        m_axis_tuser,
    input wire logic                        m_axis_tlast
);
    import sm4i_pkg::*;

    // input request holds steady until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input request changed while stalled");

    // result request holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    // singular result is a single all-zero last row
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("singular result malformed");

    // a regular matrix ends on row 3
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata[1:0] == 2'd3)
        else $error("last result is not row 3");

    // rows before row 3 are never marked last
    a_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser && (m_axis_tdata[1:0] != 2'd3) |-> !m_axis_tlast)
        else $error("early last marker");

endmodule

bind similarity_matrix4_inverse sm4i_checker u_checker (.*);
`default_nettype wire
